// File: rtl/assert_macros.svh
// Assertion macros for the port-level checker (crs_chk).
// Assumes clk and rst_n are visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CRS_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define CRS_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// File: rtl/crs_pkg.sv
// Shared constants and types for the crust/lithosphere reaction block.
// No dependencies.
`timescale 1ns / 1ps

package crs_pkg;

    localparam int DIM_DEF = 3;

    localparam int QW       = 21;
    localparam int UPW_LAT  = 8;
    localparam int DIV_LAT  = QW + 2;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [20:0] HARZ_MAX = 21'd1048575;

    localparam logic [21:0] CRUST_RST = 22'd7000;
    localparam logic [21:0] LITHO_RST = 22'd63000;
    localparam logic [16:0] SIN_RST   = 17'd32768;

    typedef enum logic [2:0] {
        REG_CRUST   = 3'd0,
        REG_LITHO   = 3'd1,
        REG_SIN_CR  = 3'd2,
        REG_SIN_LI  = 3'd3,
        REG_PROFILE = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic               in_crust;
        logic               in_lith;
        logic               base_pos;
        logic signed [17:0] bterm_c;
        logic        [16:0] base;
        logic        [16:0] harz;
    } side_t;

endpackage

// File: rtl/crs_upw.sv
// Upwelling test pipeline: squared comparison of v.(-g) against |v||g|s.
// Depends on crs_pkg for the default dimension.
`timescale 1ns / 1ps

module crs_upw #(
    parameter int DIM = crs_pkg::DIM_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] grav_x,
    input  logic signed [31:0] grav_y,
    input  logic signed [31:0] grav_z,
    input  logic        [16:0] sin_crust,
    input  logic        [16:0] sin_litho,
    output logic               up_crust,
    output logic               up_litho
);

    localparam bit USE_Z = (DIM > 2);

    logic signed [31:0]  v [3];
    logic signed [31:0]  g [3];
    logic signed [63:0]  p_vg [3];
    logic signed [63:0]  p_vv [3];
    logic signed [63:0]  p_gg [3];

    logic signed [63:0]  pvg_reg [3];
    logic        [63:0]  vv_reg [3];
    logic        [63:0]  gg_reg [3];

    logic signed [65:0]  dsum_reg;
    logic        [63:0]  v2_reg;
    logic        [63:0]  g2_reg;

    logic signed [65:0]  dneg;
    logic        [63:0]  dmag_reg;
    logic        [63:0]  v2b_reg;
    logic        [63:0]  g2b_reg;

    logic        [63:0]  pll_reg, plh_reg, phh_reg;
    logic        [63:0]  vll_reg, vlh_reg, vhl_reg, vhh_reg;

    logic        [127:0] lhs5_reg, vg_reg;
    logic        [127:0] lhs6_reg, lhs7_reg;
    logic        [33:0]  sqc_reg, sql_reg;
    logic        [65:0]  pc_reg [4];
    logic        [65:0]  pl_reg [4];
    logic        [161:0] rhs_c, rhs_l;
    logic        [161:0] rhsc_reg, rhsl_reg;
    logic        [161:0] lhs_ext;
    logic                upc_reg, upl_reg;

    assign v[0] = vel_x;
    assign v[1] = vel_y;
    assign v[2] = USE_Z ? vel_z : 32'sd0;
    assign g[0] = grav_x;
    assign g[1] = grav_y;
    assign g[2] = USE_Z ? grav_z : 32'sd0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_vg[i] = v[i] * g[i];
            p_vv[i] = v[i] * v[i];
            p_gg[i] = g[i] * g[i];
        end
    end

    assign dneg = -dsum_reg;

    always_comb
    begin
        rhs_c = '0;
        rhs_l = '0;
        for (int k = 0; k < 4; k++)
        begin
            rhs_c = rhs_c + ({96'd0, pc_reg[k]} << (32 * k));
            rhs_l = rhs_l + ({96'd0, pl_reg[k]} << (32 * k));
        end
    end

    assign lhs_ext = {2'd0, lhs7_reg, 32'd0};

    always_ff @(posedge clk)
    begin
        sqc_reg <= sin_crust * sin_crust;
        sql_reg <= sin_litho * sin_litho;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pvg_reg[i] <= p_vg[i];
                vv_reg[i]  <= $unsigned(p_vv[i]);
                gg_reg[i]  <= $unsigned(p_gg[i]);
            end

            dsum_reg <= $signed({{2{pvg_reg[0][63]}}, pvg_reg[0]})
                      + $signed({{2{pvg_reg[1][63]}}, pvg_reg[1]})
                      + $signed({{2{pvg_reg[2][63]}}, pvg_reg[2]});
            v2_reg   <= vv_reg[0] + vv_reg[1] + vv_reg[2];
            g2_reg   <= gg_reg[0] + gg_reg[1] + gg_reg[2];

            // d = -(v.g); only positive d can pass
            dmag_reg <= dsum_reg[65] ? dneg[63:0] : 64'd0;
            v2b_reg  <= v2_reg;
            g2b_reg  <= g2_reg;

            pll_reg <= dmag_reg[31:0]  * dmag_reg[31:0];
            plh_reg <= dmag_reg[31:0]  * dmag_reg[63:32];
            phh_reg <= dmag_reg[63:32] * dmag_reg[63:32];
            vll_reg <= v2b_reg[31:0]  * g2b_reg[31:0];
            vlh_reg <= v2b_reg[31:0]  * g2b_reg[63:32];
            vhl_reg <= v2b_reg[63:32] * g2b_reg[31:0];
            vhh_reg <= v2b_reg[63:32] * g2b_reg[63:32];

            lhs5_reg <= {phh_reg, 64'd0} + {31'd0, plh_reg, 33'd0} + {64'd0, pll_reg};
            vg_reg   <= {vhh_reg, 64'd0} + {32'd0, vlh_reg, 32'd0}
                      + {32'd0, vhl_reg, 32'd0} + {64'd0, vll_reg};

            for (int k = 0; k < 4; k++)
            begin
                pc_reg[k] <= vg_reg[32*k +: 32] * sqc_reg;
                pl_reg[k] <= vg_reg[32*k +: 32] * sql_reg;
            end
            lhs6_reg <= lhs5_reg;

            rhsc_reg <= rhs_c;
            rhsl_reg <= rhs_l;
            lhs7_reg <= lhs6_reg;

            upc_reg <= lhs_ext > rhsc_reg;
            upl_reg <= lhs_ext > rhsl_reg;
        end
    end

    assign up_crust = upc_reg;
    assign up_litho = upl_reg;

endmodule

// File: rtl/crs_div.sv
// Pipelined restoring divider for the linear harzburgite target, one bit a stage.
// Depends on crs_pkg for the quotient width.
`timescale 1ns / 1ps

module crs_div (
    input  logic        clk,
    input  logic        en,
    input  logic [22:0] num,
    input  logic [16:0] base,
    input  logic [21:0] den,
    output logic [crs_pkg::QW-1:0] quo,
    output logic        ovf
);

    localparam int QW = crs_pkg::QW;
    localparam int RW = 22 + QW;

    logic [39:0]    n_reg;
    logic [RW-1:0]  rem_reg [QW+1];
    logic [QW-1:0]  q_reg [QW+1];
    logic           ovf_reg [QW+1];
    logic [RW-1:0]  n_ext;
    logic [RW-1:0]  den_top;

    assign n_ext   = {{(RW-40){1'b0}}, n_reg};
    assign den_top = {den, {QW{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg      <= num * base;
            ovf_reg[0] <= n_ext >= den_top;
            rem_reg[0] <= n_ext;
            q_reg[0]   <= '0;
            for (int k = 1; k <= QW; k++)
            begin
                ovf_reg[k] <= ovf_reg[k-1];
                if (rem_reg[k-1] >= (den_top >> k))
                begin
                    rem_reg[k] <= rem_reg[k-1] - (den_top >> k);
                    q_reg[k]   <= q_reg[k-1] | (QW'(1) << (QW - k));
                end
                else
                begin
                    rem_reg[k] <= rem_reg[k-1];
                    q_reg[k]   <= q_reg[k-1];
                end
            end
        end
    end

    assign quo = q_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

// File: rtl/crust_lithosphere_reaction.sv
// Channel  | signals                   | beat
// ---------+---------------------------+----------------------------------
// item     | item_valid / item_stall   | depth, velocity, gravity, fractions
// result   | res_valid / res_stall     | basalt and harzburgite terms
// config   | APB psel/penable/pwrite   | one register write
// One beat a cycle unless a result is stalled; items pass the 21-stage divider
// plus product and check stages; the upwelling test (8 stages) runs alongside.
// Reset clears valid bits and loads register defaults; no clearing pass.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// Top level; depends on crs_pkg, crs_upw and crs_div.
`timescale 1ns / 1ps

module crust_lithosphere_reaction #(
    parameter int DIM = crs_pkg::DIM_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [21:0]        depth_m,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] grav_x,
    input  logic signed [31:0] grav_y,
    input  logic signed [31:0] grav_z,
    input  logic [16:0]        basalt_frac,
    input  logic [16:0]        harz_frac,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [17:0] basalt_term,
    output logic               basalt_set,
    output logic signed [20:0] harz_term,
    output logic               harz_set
);

    localparam int DL = crs_pkg::DIV_LAT;
    localparam int UL = crs_pkg::UPW_LAT;
    localparam int QW = crs_pkg::QW;

    logic [21:0] crust_reg, litho_reg;
    logic [16:0] sinc_reg, sinl_reg;
    logic        prof_reg;

    logic              adv;
    logic              vld_reg [DL];
    crs_pkg::side_t    side_reg [DL];
    logic [1:0]        up_dly_reg [DL-UL];
    crs_pkg::side_t    side_in;
    logic [22:0]       depth_sum;
    logic [22:0]       num;
    logic              up_c, up_l;
    logic [QW-1:0]     quo;
    logic              ovf;

    crs_pkg::side_t    sd;
    logic [1:0]        up;
    logic [QW-1:0]     qdiff;
    logic signed [17:0] bterm;
    logic signed [20:0] hterm;
    logic              bset;

    logic               res_valid_reg;
    logic signed [17:0] bterm_reg;
    logic signed [20:0] hterm_reg;
    logic               set_reg;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crust_reg <= crs_pkg::CRUST_RST;
            litho_reg <= crs_pkg::LITHO_RST;
            sinc_reg  <= crs_pkg::SIN_RST;
            sinl_reg  <= crs_pkg::SIN_RST;
            prof_reg  <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (crs_pkg::reg_idx_t'(paddr[4:2]))
                crs_pkg::REG_CRUST:   crust_reg <= pwdata[21:0];
                crs_pkg::REG_LITHO:   litho_reg <= pwdata[21:0];
                crs_pkg::REG_SIN_CR:  sinc_reg  <= pwdata[16:0];
                crs_pkg::REG_SIN_LI:  sinl_reg  <= pwdata[16:0];
                crs_pkg::REG_PROFILE: prof_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (crs_pkg::reg_idx_t'(paddr[4:2]))
            crs_pkg::REG_CRUST:   prdata = {10'd0, crust_reg};
            crs_pkg::REG_LITHO:   prdata = {10'd0, litho_reg};
            crs_pkg::REG_SIN_CR:  prdata = {15'd0, sinc_reg};
            crs_pkg::REG_SIN_LI:  prdata = {15'd0, sinl_reg};
            crs_pkg::REG_PROFILE: prdata = {31'd0, prof_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // pipeline control
    assign adv        = !(res_valid_reg && res_stall);
    assign item_stall = !adv;

    assign depth_sum = {1'b0, crust_reg} + {1'b0, litho_reg};
    assign num       = depth_sum - {1'b0, depth_m};

    always_comb
    begin
        side_in.in_crust = depth_m < crust_reg;
        side_in.in_lith  = {1'b0, depth_m} < depth_sum;
        side_in.base_pos = basalt_frac < crs_pkg::ONE_Q16;
        side_in.bterm_c  = {1'b0, crs_pkg::ONE_Q16} - {1'b0, basalt_frac};
        side_in.base     = side_in.base_pos ? (crs_pkg::ONE_Q16 - basalt_frac) : 17'd0;
        side_in.harz     = harz_frac;
    end

    crs_upw #(
        .DIM (DIM)
    ) u_upw (
        .clk       (clk),
        .en        (adv),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .grav_x    (grav_x),
        .grav_y    (grav_y),
        .grav_z    (grav_z),
        .sin_crust (sinc_reg),
        .sin_litho (sinl_reg),
        .up_crust  (up_c),
        .up_litho  (up_l)
    );

    crs_div u_div (
        .clk  (clk),
        .en   (adv),
        .num  (num),
        .base (side_in.base),
        .den  (litho_reg),
        .quo  (quo),
        .ovf  (ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DL; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int k = 1; k < DL; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            res_valid_reg <= vld_reg[DL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < DL; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            up_dly_reg[0] <= {up_c, up_l};
            for (int k = 1; k < DL - UL; k++)
            begin
                up_dly_reg[k] <= up_dly_reg[k-1];
            end
            bterm_reg <= bterm;
            hterm_reg <= hterm;
            set_reg   <= bset;
        end
    end

    // result assembly
    assign sd    = side_reg[DL-1];
    assign up    = up_dly_reg[DL-UL-1];
    assign qdiff = quo - {{(QW-17){1'b0}}, sd.harz};

    always_comb
    begin
        bterm = 18'sd0;
        hterm = 21'sd0;
        bset  = 1'b0;
        if (sd.in_crust && up[1])
        begin
            bterm = sd.bterm_c;
            hterm = -$signed({4'd0, sd.harz});
            bset  = 1'b1;
        end
        else if (sd.in_lith && up[0])
        begin
            bset = 1'b1;
            if (!sd.base_pos)
            begin
                hterm = 21'sd0;
            end
            else if (prof_reg)
            begin
                if (ovf)
                begin
                    hterm = $signed(crs_pkg::HARZ_MAX);
                end
                else if (quo > {{(QW-17){1'b0}}, sd.harz})
                begin
                    hterm = qdiff[QW-1] ? $signed(crs_pkg::HARZ_MAX)
                                        : $signed({1'b0, qdiff[QW-2:0]});
                end
            end
            else if (sd.base > sd.harz)
            begin
                hterm = $signed({4'd0, sd.base - sd.harz});
            end
        end
    end

    assign res_valid   = res_valid_reg;
    assign basalt_term = bterm_reg;
    assign basalt_set  = set_reg;
    assign harz_term   = hterm_reg;
    assign harz_set    = set_reg;

endmodule

// File: rtl/crs_chk.sv
// Port-level checker for the reaction block, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crs_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic               res_valid,
    input logic               res_stall,
    input logic signed [17:0] basalt_term,
    input logic               basalt_set,
    input logic signed [20:0] harz_term,
    input logic               harz_set
);

    `CRS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(harz_term) && $stable(basalt_term), "result beat changed under stall")

    `CRS_ASSERT_NOW(a_stall_cause, item_stall, res_valid && res_stall, "input stalled without a held result")

    `CRS_ASSERT_NOW(a_unset_zero, res_valid && !basalt_set, basalt_term == 18'sd0 && harz_term == 21'sd0, "unwritten term not zero")

    `CRS_ASSERT_NOW(a_set_pair, res_valid, basalt_set == harz_set, "set flags disagree")

endmodule

bind crust_lithosphere_reaction crs_chk u_chk (.*);

// File: tb/crust_lithosphere_reaction_check.sv
// Checker for the crust/lithosphere reaction block: watches the item and result
// channels, predicts each result and compares it. Depends on crs_pkg.
`timescale 1ns / 1ps

module crust_lithosphere_reaction_check #(
    parameter int DIM = crs_pkg::DIM_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               item_valid,
    input  logic               item_stall,
    input  logic [21:0]        depth_m,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] grav_x,
    input  logic signed [31:0] grav_y,
    input  logic signed [31:0] grav_z,
    input  logic [16:0]        basalt_frac,
    input  logic [16:0]        harz_frac,
    input  logic               res_valid,
    input  logic               res_stall,
    input  logic signed [17:0] basalt_term,
    input  logic               basalt_set,
    input  logic signed [20:0] harz_term,
    input  logic               harz_set,
    output int                 failures,
    output int                 pending
);

    typedef struct packed {
        logic signed [17:0] bterm;
        logic               bset;
        logic signed [20:0] hterm;
        logic               hset;
    } reaction_t;

    logic [21:0] crust_m, litho_m;
    logic [16:0] sin_cr, sin_li;
    logic        linear;
    reaction_t   reactions_due[$];

    assign pending = reactions_due.size();

    function automatic bit rises(bit dpos, logic [63:0] dmag, logic [63:0] v2,
                                 logic [63:0] g2, logic [16:0] s);
        logic [255:0] lhs, rhs;
        if (!dpos || dmag == 0)
            return 0;
        lhs = ({192'd0, dmag} * {192'd0, dmag}) << 32;
        rhs = {192'd0, v2} * {192'd0, g2} * {239'd0, s} * {239'd0, s};
        return lhs > rhs;
    endfunction

    function automatic reaction_t react();
        reaction_t       r;
        logic signed [63:0] v[3], g[3], p, b, h, base, num, target, hv;
        logic [63:0]     pos, neg, v2, g2, dmag;
        bit              dpos;
        r = '0;
        pos = 0; neg = 0; v2 = 0; g2 = 0;
        v[0] = vel_x; v[1] = vel_y; v[2] = (DIM < 3) ? 0 : vel_z;
        g[0] = grav_x; g[1] = grav_y; g[2] = (DIM < 3) ? 0 : grav_z;
        for (int i = 0; i < 3; i++)
        begin
            p = v[i] * g[i];
            if (p < 0)
                pos += -p;
            else
                neg += p;
            v2 += v[i] * v[i];
            g2 += g[i] * g[i];
        end
        dpos = pos > neg;
        dmag = dpos ? pos - neg : neg - pos;
        b = basalt_frac;
        h = harz_frac;
        if (depth_m < crust_m && rises(dpos, dmag, v2, g2, sin_cr))
        begin
            r.bterm = 18'(65536 - b);
            r.bset  = 1;
            r.hterm = 21'(-h);
            r.hset  = 1;
        end
        else if ({1'b0, depth_m} < {1'b0, crust_m} + {1'b0, litho_m}
                 && rises(dpos, dmag, v2, g2, sin_li))
        begin
            base = 65536 - b;
            r.bset = 1;
            r.hset = 1;
            if (base <= 0)
                hv = 0;
            else if (linear)
            begin
                if (litho_m == 0)
                    hv = crs_pkg::HARZ_MAX;
                else
                begin
                    num = crust_m + litho_m - depth_m;
                    target = (num * base) / litho_m;
                    hv = target > h ? target - h : 0;
                end
            end
            else
                hv = base > h ? base - h : 0;
            if (hv > crs_pkg::HARZ_MAX)
                hv = crs_pkg::HARZ_MAX;
            r.hterm = hv[20:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reaction_t want;
        if (!rst_n)
        begin
            crust_m  <= crs_pkg::CRUST_RST;
            litho_m  <= crs_pkg::LITHO_RST;
            sin_cr   <= crs_pkg::SIN_RST;
            sin_li   <= crs_pkg::SIN_RST;
            linear   <= 1'b1;
            failures <= 0;
            reactions_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                case (crs_pkg::reg_idx_t'(paddr[4:2]))
                    crs_pkg::REG_CRUST:   crust_m <= pwdata[21:0];
                    crs_pkg::REG_LITHO:   litho_m <= pwdata[21:0];
                    crs_pkg::REG_SIN_CR:  sin_cr  <= pwdata[16:0];
                    crs_pkg::REG_SIN_LI:  sin_li  <= pwdata[16:0];
                    crs_pkg::REG_PROFILE: linear  <= pwdata[0];
                    default: ;
                endcase
            if (item_valid && !item_stall)
                reactions_due.push_back(react());
            if (res_valid && !res_stall)
            begin
                if (reactions_due.size() == 0)
                begin
                    $error("unexpected result beat");
                    failures <= failures + 1;
                end
                else
                begin
                    want = reactions_due.pop_front();
                    if (want.bterm !== basalt_term)
                        $error("basalt_term exp %0d got %0d", want.bterm, basalt_term);
                    if (want.bset !== basalt_set)
                        $error("basalt_set exp %0d got %0d", want.bset, basalt_set);
                    if (want.hterm !== harz_term)
                        $error("harz_term exp %0d got %0d", want.hterm, harz_term);
                    if (want.hset !== harz_set)
                        $error("harz_set exp %0d got %0d", want.hset, harz_set);
                    if (want !== {basalt_term, basalt_set, harz_term, harz_set})
                        failures <= failures + 1;
                end
            end
        end
    end
endmodule

// File: tb/crust_lithosphere_reaction_test.sv
// Top of the crust/lithosphere reaction testbench: drives items, register writes
// and result stalls, and gives the verdict. Depends on crs_pkg and the checker.
`timescale 1ns / 1ps

module crust_lithosphere_reaction_test;

    localparam int WATCHDOG = 20000;

    logic               clk, rst_n;
    logic               psel, penable, pwrite, pready;
    logic [4:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               item_valid, item_stall, res_valid, res_stall;
    logic [21:0]        depth_m;
    logic signed [31:0] vel_x, vel_y, vel_z, grav_x, grav_y, grav_z;
    logic [16:0]        basalt_frac, harz_frac;
    logic signed [17:0] basalt_term;
    logic               basalt_set, harz_set;
    logic signed [20:0] harz_term;
    int                 failures, pending, idle_cycles;
    bit                 quiet, timed_out;

    crust_lithosphere_reaction uut (.*);

    crust_lithosphere_reaction_check #(.DIM(crs_pkg::DIM_DEF)) u_check (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("crust_lithosphere_reaction_test: FAIL");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        res_stall = 0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 8);
                res_stall <= 1;
                repeat (n) @(posedge clk);
                res_stall <= 0;
            end
        end
    end

    task automatic reg_write(crs_pkg::reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    function automatic logic signed [31:0] rnd_comp();
        case ($urandom_range(0, 4))
            0: return $signed($urandom);
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return 32'sh7fffffff;
            3: return 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        endcase
    endfunction

    // valid stays high between beats; it drops only for a gap or a drain
    task automatic send(logic [21:0] d, logic signed [31:0] vx, vy, vz, gx, gy, gz,
                        logic [16:0] b, h, bit gaps);
        if (gaps && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item_valid <= 1;
        depth_m <= d;
        vel_x <= vx; vel_y <= vy; vel_z <= vz;
        grav_x <= gx; grav_y <= gy; grav_z <= gz;
        basalt_frac <= b; harz_frac <= h;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic rnd_item(bit gaps);
        logic [21:0] d;
        logic signed [31:0] gz, vz;
        case ($urandom_range(0, 3))
            0: d = 22'($urandom);
            1: d = 22'($urandom_range(0, 8000));
            default: d = 22'($urandom_range(0, 80000));
        endcase
        gz = -$signed($urandom_range(1, 32'h000a0000));
        vz = $urandom_range(0, 3) == 0 ? rnd_comp() : $signed($urandom_range(0, 32'h40000));
        if ($urandom_range(0, 2) == 0)
            send(d, rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(),
                 17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)), gaps);
        else
            send(d, $signed($urandom_range(0, 2000)) - 1000, rnd_comp(), vz,
                 $signed($urandom_range(0, 200)) - 100, 0, gz,
                 17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)), gaps);
    endtask

    task automatic drain();
        item_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] cfg[5];
        quiet = 0;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        item_valid = 0; depth_m = 0;
        vel_x = 0; vel_y = 0; vel_z = 0; grav_x = 0; grav_y = 0; grav_z = 0;
        basalt_frac = 0; harz_frac = 0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed, reset settings
        send(0, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 0, 0);
        send(3000, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 65536, 65536, 0);
        send(3000, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 131071, 131071, 0);
        send(30000, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 1000, 500, 0);
        send(69999, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 0, 0);
        send(70000, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 0, 0);
        send(22'h3fffff, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 0, 0);
        send(3000, 0, 0, 0, 0, 0, -32'sh10000, 0, 0, 0);
        send(3000, 0, 0, 32'sh10000, 0, 0, 0, 0, 0, 0);
        send(3000, 0, 0, -32'sh10000, 0, 0, -32'sh10000, 0, 0, 0);
        send(3000, 32'sh10000, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 0, 0);
        send(3000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, 0);
        send(3000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
        send(30000, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 70000, 0, 0);
        drain();

        cfg = '{7000, 63000, 32768, 32768, 1};
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: cfg = '{0, 0, 0, 0, 1};
                1: cfg = '{22'h3fffff, 22'h3fffff, 65536, 65536, 0};
                2: cfg = '{5000, 1, 131071, 0, 1};
                3: cfg = '{20000, 22'h3fffff, 0, 65535, 1};
                4: cfg = '{0, 100, 60000, 20000, 0};
                default: cfg = '{7000, 63000, 32768, 32768, 1};
            endcase
            for (int i = 0; i < 5; i++)
                reg_write(crs_pkg::reg_idx_t'(i), cfg[i]);
            if (phase == 0)
            begin
                send(0, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 0, 0);
                send(0, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 65536, 0, 0);
            end
            if (phase == 5)
                quiet = 1;
            for (int k = 0; k < 80; k++)
                rnd_item(!quiet);
            drain();
        end

        if (failures == 0)
            $display("crust_lithosphere_reaction_test: PASS");
        else
            $display("crust_lithosphere_reaction_test: FAIL");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/crs_pkg.sv
rtl/crs_upw.sv
rtl/crs_div.sv
rtl/crust_lithosphere_reaction.sv
rtl/crs_chk.sv
tb/crust_lithosphere_reaction_check.sv
tb/crust_lithosphere_reaction_test.sv
